@@ sv/lpf_pkg.sv @@
// Package for the longest palindrome finder.
// Holds the default buffer size, the search sequencer states and the status
// bundle passed from the search engine back to the loader. No dependencies.
package lpf_pkg;

    // Default buffer capacity in characters
    localparam int LPF_MAX_LEN = 1024;

    // Widths of the result fields
    localparam int LPF_START_W  = 10;
    localparam int LPF_LENGTH_W = 11;

    // Search sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CENTER = 5'b00010,
        ST_ISSUE  = 5'b00100,
        ST_CMP    = 5'b01000,
        ST_DONE   = 5'b10000
    } lpf_state_t;

    // Status from the search engine to the loader
    typedef struct packed {
        logic busy;         // a search is walking the buffer
        logic search_done;  // one-cycle pulse: buffer no longer needed
    } lpf_status_t;

endpackage

@@ sv/longest_palindrome_finder.sv @@
// Top level of the longest palindrome finder: loader, job queue, two buffer
// copies and search engine. Depends on lpf_pkg and all lpf_* modules.
//
// Characters stream in one per cycle while s_ready is high and are stored in
// a MAX_LEN-byte buffer; characters past MAX_LEN are dropped and flagged as
// overflow. The item with s_last_char set ends the string and starts the
// search, which reports the start and length of the longest palindromic
// substring (ties go to the earlier even center, then the earlier odd
// center). From the accepted last character until the search has finished
// with the buffer, s_ready stays low. The job is registered in the job queue
// and popped by the search engine when it is idle; m_valid rises as the
// result register loads once the search is over. The search runs as a
// single compare loop, one character pair at a time through the buffer's
// registered read ports, and takes longest when every character is the
// same. A result waiting on m_ready does not hold off the next string; only
// the load of the following result waits for it.
module longest_palindrome_finder import lpf_pkg::*; #(
    parameter int MAX_LEN = LPF_MAX_LEN
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_char_in,
    input  logic                    s_last_char,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [LPF_START_W-1:0]  m_best_start,
    output logic [LPF_LENGTH_W-1:0] m_best_length,
    output logic                    m_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          job_push, job_pop, job_full, job_empty;
    logic [CW:0]   job_in, job_out;
    logic [AW-1:0] rd_addr_lo, rd_addr_hi;
    logic [7:0]    rd_data_lo, rd_data_hi;
    lpf_status_t   status;

    // Loader
    lpf_front #(.MAX_LEN(MAX_LEN)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_last_char (s_last_char),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .job_push    (job_push),
        .job_data    (job_in),
        .job_full    (job_full),
        .status      (status)
    );

    // Job queue
    lpf_job_queue #(.WIDTH(CW + 1)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .din     (job_in),
        .full    (job_full),
        .pop     (job_pop),
        .dout    (job_out),
        .empty   (job_empty)
    );

    // Two buffer copies, one read port each for the two span ends
    lpf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_buf_lo (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr_lo),
        .rdata (rd_data_lo)
    );

    lpf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_buf_hi (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr_hi),
        .rdata (rd_data_hi)
    );

    // Search engine
    lpf_back #(.MAX_LEN(MAX_LEN)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_empty     (job_empty),
        .job_data      (job_out),
        .job_pop       (job_pop),
        .rd_addr_lo    (rd_addr_lo),
        .rd_addr_hi    (rd_addr_hi),
        .rd_data_lo    (rd_data_lo),
        .rd_data_hi    (rd_data_hi),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_start  (m_best_start),
        .m_best_length (m_best_length),
        .m_overflow    (m_overflow)
    );

    // Buffer must not be written while the search walks it
    a_no_load_in_search: assert property (
        @(posedge aclk) disable iff (!aresetn)
        status.busy |-> !s_ready
    ) else $error("character accepted during search");

    // Last character holds off the next string
    a_hold_after_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_char) |=> !s_ready
    ) else $error("input not held off after last character");

    // A reported palindrome is never empty
    a_len_nonzero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_best_length != '0)
    ) else $error("zero-length result");

endmodule

@@ sv/lpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the character buffer. No dependencies.
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lpf_job_queue.sv @@
// Two-entry queue of search jobs (character count and overflow flag)
// between the loader and the search engine. No dependencies.
module lpf_job_queue #(
    parameter int WIDTH = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       fill_reg, fill_next;

    // Pointer and fill bookkeeping
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push && !full) begin
            wptr_next = ~wptr_reg;
        end
        if (pop && !empty) begin
            rptr_next = ~rptr_reg;
        end
        if ((push && !full) && !(pop && !empty)) begin
            fill_next = fill_reg + 2'd1;
        end else if (!(push && !full) && (pop && !empty)) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wptr_reg] <= din;
        end
    end

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign dout  = slot_reg[rptr_reg];

endmodule

@@ sv/lpf_front.sv @@
// Loader: accepts characters, writes them to the buffer, counts them and
// queues a search job on the last one. Depends on lpf_pkg.
module lpf_front import lpf_pkg::*; #(
    parameter int MAX_LEN = LPF_MAX_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_in,
    input  logic                       s_last_char,
    output logic                       wr_en,
    output logic [$clog2(MAX_LEN)-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output logic                       job_push,
    output logic [$clog2(MAX_LEN+1):0] job_data,
    input  logic                       job_full,
    input  lpf_status_t                status
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          hold_reg, hold_next;
    logic          accept;
    logic          room;

    assign s_ready = !hold_reg && !job_full;
    assign accept  = s_valid && s_ready;
    assign room    = (count_reg < CW'(MAX_LEN));

    // Buffer write
    assign wr_en   = accept && room;
    assign wr_addr = AW'(count_reg);
    assign wr_data = s_char_in;

    // Count, overflow and hold-off until the search is done with the buffer
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        hold_next  = hold_reg;
        job_push   = 1'b0;
        if (status.search_done) begin
            hold_next = 1'b0;
        end
        if (accept) begin
            if (room) begin
                count_next = count_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
            if (s_last_char) begin
                job_push  = 1'b1;
                hold_next = 1'b1;
            end
        end
        job_data = {ovf_next, count_next};
        if (accept && s_last_char) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            hold_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

@@ sv/lpf_back.sv @@
// Search engine: expands around every even then every odd center, reading
// both ends from the buffer copies, and drives the result register.
// Depends on lpf_pkg.
module lpf_back import lpf_pkg::*; #(
    parameter int MAX_LEN = LPF_MAX_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_empty,
    input  logic [$clog2(MAX_LEN+1):0] job_data,
    output logic                       job_pop,
    output logic [$clog2(MAX_LEN)-1:0] rd_addr_lo,
    output logic [$clog2(MAX_LEN)-1:0] rd_addr_hi,
    input  logic [7:0]                 rd_data_lo,
    input  logic [7:0]                 rd_data_hi,
    output lpf_status_t                status,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LPF_START_W-1:0]     m_best_start,
    output logic [LPF_LENGTH_W-1:0]    m_best_length,
    output logic                       m_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    lpf_state_t     state_reg, state_next;
    logic [CW-1:0]  n_reg, n_next;
    logic           ovf_reg, ovf_next;
    logic [CW-1:0]  c_reg, c_next;          // center index
    logic           phase_reg, phase_next;  // 0: even centers, 1: odd
    logic [CW-1:0]  st_reg, st_next;        // start of span (left end + 1)
    logic [CW-1:0]  hi_reg, hi_next;        // right end probe
    logic [AW-1:0]  best_start_reg, best_start_next;
    logic [CW-1:0]  best_len_reg, best_len_next;
    logic           m_valid_reg, m_valid_next;
    logic [LPF_START_W-1:0]  out_start_reg;
    logic [LPF_LENGTH_W-1:0] out_len_reg;
    logic           out_ovf_reg;
    logic           out_load;

    logic [CW:0]    hi_init;
    logic           can_read;
    logic [CW-1:0]  span;
    logic           better;

    // First right probe of the current center
    assign hi_init = {1'b0, c_reg} + (CW + 1)'(1) + (CW + 1)'(phase_reg);
    // Both ends inside the string
    assign can_read = (st_reg != '0) && (hi_reg < n_reg);
    assign span     = hi_reg - st_reg;
    assign better   = (span > best_len_reg);

    assign rd_addr_lo = AW'(st_reg - CW'(1));
    assign rd_addr_hi = AW'(hi_reg);

    // Search sequencer
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        ovf_next        = ovf_reg;
        c_next          = c_reg;
        phase_next      = phase_reg;
        st_next         = st_reg;
        hi_next         = hi_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        job_pop         = 1'b0;
        out_load        = 1'b0;
        status          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!job_empty) begin
                    job_pop         = 1'b1;
                    n_next          = job_data[CW-1:0];
                    ovf_next        = job_data[CW];
                    c_next          = '0;
                    phase_next      = 1'b0;
                    best_start_next = '0;
                    best_len_next   = CW'(1);
                    state_next      = ST_CENTER;
                end
            end
            ST_CENTER: begin
                status.busy = 1'b1;
                if (hi_init < {1'b0, n_reg}) begin
                    st_next    = c_reg + CW'(1);
                    hi_next    = CW'(hi_init);
                    state_next = ST_ISSUE;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                    c_next     = '0;
                end else begin
                    status.search_done = 1'b1;
                    state_next         = ST_DONE;
                end
            end
            ST_ISSUE: begin
                status.busy = 1'b1;
                if (can_read) begin
                    state_next = ST_CMP;
                end else begin
                    if (better) begin
                        best_len_next   = span;
                        best_start_next = AW'(st_reg);
                    end
                    c_next     = c_reg + CW'(1);
                    state_next = ST_CENTER;
                end
            end
            ST_CMP: begin
                status.busy = 1'b1;
                if (rd_data_lo == rd_data_hi) begin
                    st_next    = st_reg - CW'(1);
                    hi_next    = hi_reg + CW'(1);
                    state_next = ST_ISSUE;
                end else begin
                    if (better) begin
                        best_len_next   = span;
                        best_start_next = AW'(st_reg);
                    end
                    c_next     = c_reg + CW'(1);
                    state_next = ST_CENTER;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        ovf_reg        <= ovf_next;
        c_reg          <= c_next;
        phase_reg      <= phase_next;
        st_reg         <= st_next;
        hi_reg         <= hi_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        if (out_load) begin
            out_start_reg <= LPF_START_W'(best_start_reg);
            out_len_reg   <= LPF_LENGTH_W'(best_len_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_best_start  = out_start_reg;
    assign m_best_length = out_len_reg;
    assign m_overflow    = out_ovf_reg;

endmodule
